[hw/rtl/searchable_deque_defines.svh]
// ----------------------------------------------------------------------------
// searchable_deque_defines.svh
// Assertion macros for the deque RTL, used by sdq_ctrl.
// ----------------------------------------------------------------------------
`ifndef SEARCHABLE_DEQUE_DEFINES_SVH
`define SEARCHABLE_DEQUE_DEFINES_SVH

// Checked on every clock edge, idle while reset is held.
`define SDQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every clock edge, reset included.
`define SDQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[hw/rtl/sdq_pkg.sv]
// ----------------------------------------------------------------------------
// sdq_pkg
// Types, constants and ring arithmetic for the searchable deque.
// ----------------------------------------------------------------------------
`default_nettype none

package sdq_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int KEY_W  = 32;
    localparam int PAY_W  = 32;
    localparam int REC_W  = KEY_W + PAY_W;
    localparam int CMD_W  = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_POP_FRONT  = 3'd1,
        CMD_SEARCH     = 3'd2,
        CMD_PUSH_FRONT = 3'd3,
        CMD_POP_BACK   = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_HOLD
    } t_state;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [REC_W-1:0]  wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic               valid;
        t_status            status;
        logic [KEY_W-1:0]   key;
        logic [PAY_W-1:0]   payload;
    } t_result;

    // (base + off) mod DEPTH; base < DEPTH and off <= DEPTH keep one subtract enough
    function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] base,
                                                   input logic [CNT_W-1:0]  off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

[hw/rtl/sdq_ram.sv]
// ----------------------------------------------------------------------------
// sdq_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sdq_ram #(
    parameter int DATA_W = 64,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output      logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/sdq_ctrl.sv]
// ----------------------------------------------------------------------------
// sdq_ctrl
// Command sequencer: ring pointers, record RAM accesses and key scan.
// ----------------------------------------------------------------------------
`default_nettype none

`include "searchable_deque_defines.svh"

module sdq_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    input  wire logic [sdq_pkg::CMD_W-1:0]    i_command,
    input  wire logic signed [sdq_pkg::KEY_W-1:0] i_key,
    input  wire logic [sdq_pkg::PAY_W-1:0]    i_payload,
    output      logic                         o_in_stall,
    input  wire logic                         i_out_free,
    output      sdq_pkg::t_result             o_res,
    output      sdq_pkg::t_mem_req            o_mem,
    input  wire logic [sdq_pkg::REC_W-1:0]    i_rdata
);

    sdq_pkg::t_state r_state, n_state;
    logic [sdq_pkg::ADDR_W-1:0] r_head, n_head;
    logic [sdq_pkg::CNT_W-1:0]  r_count, n_count;
    logic [sdq_pkg::CNT_W-1:0]  r_idx, n_idx;
    logic [sdq_pkg::KEY_W-1:0]  r_key, n_key;
    sdq_pkg::t_status           r_status, n_status;
    logic [sdq_pkg::KEY_W-1:0]  r_res_key, n_res_key;
    logic [sdq_pkg::PAY_W-1:0]  r_res_payload, n_res_payload;

    logic w_accept;
    logic w_full;
    logic w_empty;
    logic w_match;
    logic w_last;
    logic [sdq_pkg::CNT_W-1:0] w_idx_inc;

    assign w_accept  = i_in_valid && (r_state == sdq_pkg::S_IDLE);
    assign w_full    = (r_count == sdq_pkg::CNT_W'(sdq_pkg::DEPTH));
    assign w_empty   = (r_count == '0);
    assign w_match   = (i_rdata[sdq_pkg::REC_W-1:sdq_pkg::PAY_W] == r_key);
    assign w_idx_inc = r_idx + 1'b1;
    assign w_last    = (w_idx_inc == r_count);

    assign o_in_stall = (r_state != sdq_pkg::S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sdq_pkg::S_IDLE: begin
                if (w_accept) begin
                    unique case (sdq_pkg::t_cmd'(i_command)) inside
                        sdq_pkg::CMD_POP_FRONT,
                        sdq_pkg::CMD_POP_BACK: n_state = w_empty ? sdq_pkg::S_HOLD
                                                                 : sdq_pkg::S_READ;
                        sdq_pkg::CMD_SEARCH:   n_state = w_empty ? sdq_pkg::S_HOLD
                                                                 : sdq_pkg::S_SCAN;
                        default:               n_state = sdq_pkg::S_HOLD;
                    endcase
                end
            end
            sdq_pkg::S_READ: n_state = sdq_pkg::S_HOLD;
            sdq_pkg::S_SCAN: begin
                if (w_match || w_last) begin
                    n_state = sdq_pkg::S_HOLD;
                end
            end
            sdq_pkg::S_HOLD: begin
                if (i_out_free) begin
                    n_state = sdq_pkg::S_IDLE;
                end
            end
            default: n_state = sdq_pkg::S_IDLE;
        endcase
    end

    // datapath and RAM requests
    always_comb begin
        n_head        = r_head;
        n_count       = r_count;
        n_idx         = r_idx;
        n_key         = r_key;
        n_status      = r_status;
        n_res_key     = r_res_key;
        n_res_payload = r_res_payload;
        o_mem         = '0;

        unique case (r_state)
            sdq_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_key         = i_key;
                    n_status      = sdq_pkg::ST_OK;
                    n_res_key     = '0;
                    n_res_payload = '0;
                    unique case (sdq_pkg::t_cmd'(i_command))
                        sdq_pkg::CMD_PUSH_BACK: begin
                            if (w_full) begin
                                n_status = sdq_pkg::ST_FULL;
                            end else begin
                                o_mem.we    = 1'b1;
                                o_mem.waddr = sdq_pkg::ring_add(r_head, r_count);
                                o_mem.wdata = {i_key, i_payload};
                                n_count     = r_count + 1'b1;
                            end
                        end
                        sdq_pkg::CMD_PUSH_FRONT: begin
                            if (w_full) begin
                                n_status = sdq_pkg::ST_FULL;
                            end else begin
                                n_head = (r_head == '0)
                                       ? sdq_pkg::ADDR_W'(sdq_pkg::DEPTH - 1)
                                       : r_head - 1'b1;
                                o_mem.we    = 1'b1;
                                o_mem.waddr = n_head;
                                o_mem.wdata = {i_key, i_payload};
                                n_count     = r_count + 1'b1;
                            end
                        end
                        sdq_pkg::CMD_POP_FRONT: begin
                            if (w_empty) begin
                                n_status = sdq_pkg::ST_EMPTY;
                            end else begin
                                o_mem.re    = 1'b1;
                                o_mem.raddr = r_head;
                                n_head      = sdq_pkg::ring_add(r_head,
                                                                sdq_pkg::CNT_W'(1));
                                n_count     = r_count - 1'b1;
                            end
                        end
                        sdq_pkg::CMD_POP_BACK: begin
                            if (w_empty) begin
                                n_status = sdq_pkg::ST_EMPTY;
                            end else begin
                                o_mem.re    = 1'b1;
                                o_mem.raddr = sdq_pkg::ring_add(r_head, r_count - 1'b1);
                                n_count     = r_count - 1'b1;
                            end
                        end
                        sdq_pkg::CMD_SEARCH: begin
                            if (w_empty) begin
                                n_status = sdq_pkg::ST_MISSING;
                            end else begin
                                o_mem.re    = 1'b1;
                                o_mem.raddr = r_head;
                                n_idx       = '0;
                            end
                        end
                        default: ;  // unused codes: OK, head and count unchanged
                    endcase
                end
            end
            sdq_pkg::S_READ: begin
                n_status      = sdq_pkg::ST_OK;
                n_res_key     = i_rdata[sdq_pkg::REC_W-1:sdq_pkg::PAY_W];
                n_res_payload = i_rdata[sdq_pkg::PAY_W-1:0];
            end
            sdq_pkg::S_SCAN: begin
                if (w_match) begin
                    n_status      = sdq_pkg::ST_OK;
                    n_res_key     = i_rdata[sdq_pkg::REC_W-1:sdq_pkg::PAY_W];
                    n_res_payload = i_rdata[sdq_pkg::PAY_W-1:0];
                end else if (w_last) begin
                    n_status      = sdq_pkg::ST_MISSING;
                    n_res_key     = '0;
                    n_res_payload = '0;
                end else begin
                    // fetch the next record in front-to-back order
                    o_mem.re    = 1'b1;
                    o_mem.raddr = sdq_pkg::ring_add(r_head, w_idx_inc);
                    n_idx       = w_idx_inc;
                end
            end
            sdq_pkg::S_HOLD: ;
            default: ;
        endcase

        o_res.valid   = (r_state == sdq_pkg::S_HOLD);
        o_res.status  = r_status;
        o_res.key     = r_res_key;
        o_res.payload = r_res_payload;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdq_pkg::S_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_key         <= n_key;
        r_status      <= n_status;
        r_res_key     <= n_res_key;
        r_res_payload <= n_res_payload;
    end

    `SDQ_ASSERT(a_count_bound, r_count <= sdq_pkg::CNT_W'(sdq_pkg::DEPTH), "count above depth")
    `SDQ_ASSERT(a_scan_in_range, (r_state == sdq_pkg::S_SCAN) |-> (r_idx < r_count), "scan past last record")
    `SDQ_ASSERT(a_push_grows, (w_accept && !w_full && (i_command == sdq_pkg::CMD_PUSH_BACK || i_command == sdq_pkg::CMD_PUSH_FRONT)) |=> (r_count == $past(r_count) + 1'b1), "push did not grow count")
    `SDQ_ASSERT(a_hit_key, (r_state == sdq_pkg::S_HOLD && r_status == sdq_pkg::ST_OK && r_res_key != '0) |-> (r_res_key == r_key || i_rdata[sdq_pkg::REC_W-1:sdq_pkg::PAY_W] == r_res_key), "result key not from record")

endmodule

`default_nettype wire

[hw/rtl/searchable_deque.sv]
// ----------------------------------------------------------------------------
// searchable_deque
// Bounded double-ended record queue in a RAM ring, with front-to-back key search.
// ----------------------------------------------------------------------------
//   channel   direction  handshake                 words
//   in        input      i_in_valid / o_in_stall   i_command, i_key, i_payload
//   out       output     o_out_valid / i_out_stall o_status, o_found_key,
//                                                  o_found_payload
//
// Push: result via the hold state and the output register; pop: read state first
// (one RAM read). Search: N records compared one per cycle through the single
// RAM read port, N up to DEPTH.
// Reset clears state, head, count and output valid only; the record RAM needs no clearing pass.
// A result waiting on a stalled output holds off the next input word.
// ----------------------------------------------------------------------------
`default_nettype none

module searchable_deque (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output      logic                             o_in_stall,
    input  wire logic [sdq_pkg::CMD_W-1:0]        i_command,
    input  wire logic signed [sdq_pkg::KEY_W-1:0] i_key,
    input  wire logic [sdq_pkg::PAY_W-1:0]        i_payload,
    output      logic                             o_out_valid,
    input  wire logic                             i_out_stall,
    output      logic [1:0]                       o_status,
    output      logic signed [sdq_pkg::KEY_W-1:0] o_found_key,
    output      logic [sdq_pkg::PAY_W-1:0]        o_found_payload
);

    sdq_pkg::t_result  w_res;
    sdq_pkg::t_mem_req w_mem;
    logic [sdq_pkg::REC_W-1:0] w_rdata;
    logic w_out_free;

    logic                      r_out_valid;
    logic [1:0]                r_status;
    logic [sdq_pkg::KEY_W-1:0] r_key;
    logic [sdq_pkg::PAY_W-1:0] r_payload;

    assign w_out_free = !r_out_valid || !i_out_stall;

    sdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .i_key      (i_key),
        .i_payload  (i_payload),
        .o_in_stall (o_in_stall),
        .i_out_free (w_out_free),
        .o_res      (w_res),
        .o_mem      (w_mem),
        .i_rdata    (w_rdata)
    );

    sdq_ram #(
        .DATA_W (sdq_pkg::REC_W),
        .DEPTH  (sdq_pkg::DEPTH),
        .ADDR_W (sdq_pkg::ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_mem.wdata),
        .i_re    (w_mem.re),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_rdata)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res.valid && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.valid && w_out_free) begin
            r_status  <= w_res.status;
            r_key     <= w_res.key;
            r_payload <= w_res.payload;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_found_key     = r_key;
    assign o_found_payload = r_payload;

endmodule

`default_nettype wire
